[src/quarter_disc_span_fill_unit_assert.svh]
// assertion macros for the quarter disc span fill unit
// expects clk and rst_n in the scope of every use
`ifndef QUARTER_DISC_SPAN_FILL_UNIT_ASSERT_SVH
`define QUARTER_DISC_SPAN_FILL_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define QDSF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define QDSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/qdsf_pkg.sv]
// shared types and constants for the quarter disc span fill unit
// no dependencies
package qdsf_pkg;

    localparam int COORD_BITS   = 10;
    localparam int WIDE_BITS    = COORD_BITS + 2;
    localparam int RADIUS_BITS  = 6;
    localparam int COLOR_BITS   = 16;
    localparam int QUAD_BITS    = 2;
    localparam int MAX_RADIUS   = 60;

    // quadrant bits
    localparam int QUAD_LEFT_BIT = 0;
    localparam int QUAD_DOWN_BIT = 1;

    // one command item
    typedef struct packed {
        logic [COORD_BITS-1:0]  center_x;
        logic [COORD_BITS-1:0]  center_y;
        logic [RADIUS_BITS-1:0] radius;
        logic [COLOR_BITS-1:0]  fill_color;
        logic [QUAD_BITS-1:0]   quadrant;
    } cmd_t;

    // one span item
    typedef struct packed {
        logic signed [WIDE_BITS-1:0] span_row;
        logic [COORD_BITS-1:0]       span_from;
        logic signed [WIDE_BITS-1:0] span_to;
        logic [COLOR_BITS-1:0]       span_color;
        logic                        last_span;
    } span_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture command, start walk
        logic emit;     // register a span on the output
        logic sel_b;    // span with row and column offsets swapped
        logic last;     // mark emitted span as last
        logic step_a;   // decision negative: x advances only
        logic step_b;   // decision non-negative: x advances, y retreats
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic rad_nonzero;  // incoming radius is not zero
        logic d_neg;        // decision variable negative
        logic a_next_lt;    // x + 1 < y
        logic b_next_lt;    // x + 1 < y - 1
        logic b_next_eq;    // x + 1 == y - 1
    } dp_status_t;

endpackage

[src/quarter_disc_span_fill_unit.sv]
// top level of the quarter disc span fill unit
// uses qdsf_pkg, qdsf_ctrl, qdsf_datapath and the assertion macro header

// A command item is taken on a clock edge with start high and busy low. The
// unit then walks the midpoint decision variable and produces one
// horizontal span per clock while busy. A command yields the clamped radius
// plus one spans, so 1 for radius zero and at most 61 at the largest radius;
// busy stays high from the accept edge until the last span is shown. Each
// span appears on result with result_valid high for exactly one cycle,
// registered from the walk state that made it, and must be taken then: the
// receiver cannot stall. The final span carries last_span. busy falls in
// the cycle the last span is shown, so the next command can be accepted
// while that span is on the output.
`include "quarter_disc_span_fill_unit_assert.svh"

module quarter_disc_span_fill_unit #(
    parameter int MAX_RADIUS = qdsf_pkg::MAX_RADIUS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  qdsf_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              result_valid,
    output qdsf_pkg::span_t   result
);

    qdsf_pkg::dp_cmd_t    dp_cmd;
    qdsf_pkg::dp_status_t dp_status;

    // sequencer
    qdsf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .dp_cmd (dp_cmd),
        .busy   (busy)
    );

    // walk arithmetic and output register
    qdsf_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_cmd       (dp_cmd),
        .status       (dp_status),
        .result_valid (result_valid),
        .result       (result)
    );

    // checks
    `QDSF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `QDSF_ASSERT_NOW(a_last_idle, result_valid && result.last_span, !busy, "busy after last span")
    `QDSF_ASSERT_NOW(a_mid_busy, result_valid && !result.last_span, busy, "idle after non-last span")
    `QDSF_ASSERT_NOW(a_fall_last, $fell(busy), result_valid && result.last_span, "busy fell without last span")

endmodule

[src/qdsf_ctrl.sv]
// walk sequencer for the quarter disc span fill unit
// uses qdsf_pkg command and status types
module qdsf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  qdsf_pkg::dp_status_t   status,
    output qdsf_pkg::dp_cmd_t      dp_cmd,
    output logic                   busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_A    = 2'd1;
    localparam logic [1:0] ST_B    = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = status.rad_nonzero ? ST_A : ST_FIN;
                end
            end
            ST_A:
            begin
                dp_cmd.emit = 1'b1;
                if (status.d_neg)
                begin
                    dp_cmd.step_a = 1'b1;
                    state_next    = status.a_next_lt ? ST_A : ST_FIN;
                end
                else
                begin
                    state_next = ST_B;
                end
            end
            ST_B:
            begin
                dp_cmd.emit   = 1'b1;
                dp_cmd.sel_b  = 1'b1;
                dp_cmd.step_b = 1'b1;
                if (status.b_next_lt)
                begin
                    state_next = ST_A;
                end
                else if (status.b_next_eq)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    dp_cmd.last = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                dp_cmd.emit = 1'b1;
                dp_cmd.last = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[src/qdsf_datapath.sv]
// walk registers, decision arithmetic and span output register
// uses qdsf_pkg item, command and status types
module qdsf_datapath #(
    parameter int MAX_RADIUS = qdsf_pkg::MAX_RADIUS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qdsf_pkg::cmd_t         cmd,
    input  qdsf_pkg::dp_cmd_t      dp_cmd,
    output qdsf_pkg::dp_status_t   status,
    output logic                   result_valid,
    output qdsf_pkg::span_t        result
);

    localparam int STEP_W  = $clog2(MAX_RADIUS + 1);
    localparam int DEC_W   = STEP_W + 5;
    localparam int WIDE_W  = qdsf_pkg::WIDE_BITS;
    localparam int COORD_W = qdsf_pkg::COORD_BITS;
    localparam int RAD_W   = qdsf_pkg::RADIUS_BITS;

    // walk state
    logic [STEP_W-1:0]               tx_reg, tx_next;
    logic [STEP_W-1:0]               ty_reg, ty_next;
    logic signed [DEC_W-1:0]         dec_reg, dec_next;

    // held command
    logic [COORD_W-1:0]              cx_reg;
    logic [COORD_W-1:0]              cy_reg;
    logic [qdsf_pkg::COLOR_BITS-1:0] color_reg;
    logic [qdsf_pkg::QUAD_BITS-1:0]  quad_reg;

    // output register
    qdsf_pkg::span_t                 span_reg, span_next;
    logic                            valid_reg;

    logic [RAD_W-1:0]                rad_clamped;
    logic [STEP_W-1:0]               start_ty;
    logic signed [DEC_W-1:0]         tx4, ty4, dec_init, dec_a, dec_b;
    logic [STEP_W:0]                 tx_p1, tx_p2, ty_e;
    logic [STEP_W-1:0]               off_row, off_col;
    logic [WIDE_W-1:0]               cx_w, cy_w, row_w, col_w;

    // radius clamp and decision start value 3 - 2r
    always_comb
    begin
        rad_clamped = (cmd.radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cmd.radius;
        start_ty    = rad_clamped[STEP_W-1:0];
        dec_init    = DEC_W'(3) - (DEC_W'(start_ty) <<< 1);
    end

    // decision updates
    always_comb
    begin
        tx4   = DEC_W'(tx_reg) <<< 2;
        ty4   = DEC_W'(ty_reg) <<< 2;
        dec_a = dec_reg + tx4 + DEC_W'(6);
        dec_b = dec_reg + tx4 - ty4 + DEC_W'(10);
    end

    // loop bound compares for the controller
    always_comb
    begin
        tx_p1 = {1'b0, tx_reg} + (STEP_W+1)'(1);
        tx_p2 = {1'b0, tx_reg} + (STEP_W+1)'(2);
        ty_e  = {1'b0, ty_reg};
        status.rad_nonzero = (cmd.radius != '0);
        status.d_neg       = dec_reg[DEC_W-1];
        status.a_next_lt   = (tx_p1 < ty_e);
        status.b_next_lt   = (tx_p2 < ty_e);
        status.b_next_eq   = (tx_p2 == ty_e);
    end

    // walk state next values
    always_comb
    begin
        tx_next  = tx_reg;
        ty_next  = ty_reg;
        dec_next = dec_reg;
        if (dp_cmd.load)
        begin
            tx_next  = '0;
            ty_next  = start_ty;
            dec_next = dec_init;
        end
        else if (dp_cmd.step_a)
        begin
            tx_next  = tx_reg + STEP_W'(1);
            dec_next = dec_a;
        end
        else if (dp_cmd.step_b)
        begin
            tx_next  = tx_reg + STEP_W'(1);
            ty_next  = ty_reg - STEP_W'(1);
            dec_next = dec_b;
        end
    end

    // span coordinates: row offset and column offset swap on the b span
    always_comb
    begin
        off_row = dp_cmd.sel_b ? ty_reg : tx_reg;
        off_col = dp_cmd.sel_b ? tx_reg : ty_reg;
        cx_w    = WIDE_W'(cx_reg);
        cy_w    = WIDE_W'(cy_reg);
        if (quad_reg[qdsf_pkg::QUAD_DOWN_BIT])
        begin
            row_w = cy_w + WIDE_W'(off_row);
        end
        else
        begin
            row_w = cy_w - WIDE_W'(off_row);
        end
        if (quad_reg[qdsf_pkg::QUAD_LEFT_BIT])
        begin
            col_w = cx_w - WIDE_W'(off_col);
        end
        else
        begin
            col_w = cx_w + WIDE_W'(off_col);
        end
        span_next.span_row   = row_w;
        span_next.span_from  = cx_reg;
        span_next.span_to    = col_w;
        span_next.span_color = color_reg;
        span_next.last_span  = dp_cmd.last;
    end

    // walk, command and span output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg    <= '0;
            ty_reg    <= '0;
            dec_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            color_reg <= '0;
            quad_reg  <= '0;
            span_reg  <= '0;
        end
        else
        begin
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            dec_reg <= dec_next;
            if (dp_cmd.load)
            begin
                cx_reg    <= cmd.center_x;
                cy_reg    <= cmd.center_y;
                color_reg <= cmd.fill_color;
                quad_reg  <= cmd.quadrant;
            end
            if (dp_cmd.emit)
            begin
                span_reg <= span_next;
            end
        end
    end

    // output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dp_cmd.emit;
        end
    end

    assign result_valid = valid_reg;
    assign result       = span_reg;

endmodule
